// File: hw/rtl/vaa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vaa_pkg: shared constants and types for the vector angle/axis pipeline
// Widths of the coordinate, product and Q-format paths, and the sideband
// record that travels beside the root lanes.
// ----------------------------------------------------------------------------
package vaa_pkg;

  // Input and fixed-point format.
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int VEC_LEN    = 3;

  // Result field widths.
  localparam int W_COS  = 16;
  localparam int W_SIN  = 15;
  localparam int W_AXIS = 16;

  // Product and sum widths.
  localparam int PROD_W = 2 * COORD_BITS;  // one coordinate product
  localparam int DOT_W  = PROD_W + 2;      // sum of three products
  localparam int CRS_W  = PROD_W + 1;      // one cross product component
  localparam int MAG_W  = 2 * COORD_BITS;  // |dot|, |c_i|, |a|^2, |b|^2
  localparam int SQ_W   = 2 * MAG_W;       // squared magnitudes and |a|^2|b|^2

  // Root lane: quotient of num * 4^(FRAC_BITS+1) / den, then its square root.
  localparam int DIV_STEPS   = 2 * FRAC_BITS + 2;
  localparam int Q_W         = DIV_STEPS + 1;
  localparam int SQ_STEPS    = (Q_W + 1) / 2;
  localparam int S_W         = SQ_STEPS;
  localparam int SR_W        = S_W + 1;
  localparam int K_W         = FRAC_BITS + 1;
  localparam int LANE_STAGES = 1 + DIV_STEPS + SQ_STEPS;

  // 1.0 in Q format.
  localparam logic [K_W-1:0] ONE = K_W'(1) << FRAC_BITS;

  // Control that rides beside the data words.
  typedef struct packed {
    logic               valid;
    logic               deg;
    logic               neg_dot;
    logic [VEC_LEN-1:0] neg_c;
    logic               cc_zero;
  } side_t;

endpackage

// File: hw/rtl/vaa_root_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vaa_root_lane: pipelined nearest-integer 2^F * sqrt(num / den)
// A restoring divider forms floor(num * 4^(F+1) / den), one quotient bit per
// stage; a digit-by-digit square root follows, one result bit per stage.
// The code k is (s + 1) / 2 where s is that square root. num <= den.
// ----------------------------------------------------------------------------
module vaa_root_lane (
  input  logic                       clk,
  input  logic                       en_i,
  input  logic [vaa_pkg::SQ_W-1:0]   num_i,
  input  logic [vaa_pkg::SQ_W-1:0]   den_i,
  output logic [vaa_pkg::K_W-1:0]    k_o
);

  localparam int SQ_W      = vaa_pkg::SQ_W;
  localparam int DIV_STEPS = vaa_pkg::DIV_STEPS;
  localparam int Q_W       = vaa_pkg::Q_W;
  localparam int SQ_STEPS  = vaa_pkg::SQ_STEPS;
  localparam int S_W       = vaa_pkg::S_W;
  localparam int SR_W      = vaa_pkg::SR_W;
  localparam int K_W       = vaa_pkg::K_W;
  localparam int X_W       = 2 * SQ_STEPS;

  // Divider stage registers.
  logic [SQ_W-1:0] drem_r   [DIV_STEPS+1];
  logic [SQ_W-1:0] drem_nxt [DIV_STEPS+1];
  logic [SQ_W-1:0] dden_r   [DIV_STEPS+1];
  logic [SQ_W-1:0] dden_nxt [DIV_STEPS+1];
  logic [Q_W-1:0]  dq_r     [DIV_STEPS+1];
  logic [Q_W-1:0]  dq_nxt   [DIV_STEPS+1];
  logic [SQ_W:0]   dtwo     [DIV_STEPS];
  logic [SQ_W:0]   dsub     [DIV_STEPS];
  logic            dge      [DIV_STEPS];
  logic            init_ge;

  // Square root stage registers.
  logic [SR_W-1:0] srem_r   [SQ_STEPS];
  logic [SR_W-1:0] srem_nxt [SQ_STEPS];
  logic [S_W-1:0]  sres_r   [SQ_STEPS];
  logic [S_W-1:0]  sres_nxt [SQ_STEPS];
  logic [X_W-1:0]  sx_r     [SQ_STEPS];
  logic [X_W-1:0]  sx_nxt   [SQ_STEPS];
  logic [SR_W-1:0] sp_rem   [SQ_STEPS];
  logic [S_W-1:0]  sp_res   [SQ_STEPS];
  logic [X_W-1:0]  sp_x     [SQ_STEPS];
  logic [SR_W+1:0] s_r4     [SQ_STEPS];
  logic [SR_W+1:0] s_trial  [SQ_STEPS];
  logic [SR_W+1:0] s_diff   [SQ_STEPS];
  logic            s_ge     [SQ_STEPS];
  logic [S_W:0]    s_inc;

  // Divider: the top quotient bit is set only when num equals den.
  always_comb begin
    init_ge     = num_i >= den_i;
    drem_nxt[0] = init_ge ? (num_i - den_i) : num_i;
    dden_nxt[0] = den_i;
    dq_nxt[0]   = Q_W'(init_ge);
    for (int i = 1; i <= DIV_STEPS; i++) begin
      dtwo[i-1]   = {drem_r[i-1], 1'b0};
      dsub[i-1]   = dtwo[i-1] - {1'b0, dden_r[i-1]};
      dge[i-1]    = dtwo[i-1] >= {1'b0, dden_r[i-1]};
      drem_nxt[i] = dge[i-1] ? dsub[i-1][SQ_W-1:0] : dtwo[i-1][SQ_W-1:0];
      dden_nxt[i] = dden_r[i-1];
      dq_nxt[i]   = {dq_r[i-1][Q_W-2:0], dge[i-1]};
    end
  end

  // Square root: two radicand bits enter each stage.
  always_comb begin
    for (int j = 0; j < SQ_STEPS; j++) begin
      if (j == 0) begin
        sp_rem[j] = '0;
        sp_res[j] = '0;
        sp_x[j]   = X_W'(dq_r[DIV_STEPS]);
      end else begin
        sp_rem[j] = srem_r[j-1];
        sp_res[j] = sres_r[j-1];
        sp_x[j]   = sx_r[j-1];
      end
      s_r4[j]     = {sp_rem[j], sp_x[j][X_W-1:X_W-2]};
      s_trial[j]  = {1'b0, sp_res[j], 2'b01};
      s_diff[j]   = s_r4[j] - s_trial[j];
      s_ge[j]     = s_r4[j] >= s_trial[j];
      srem_nxt[j] = s_ge[j] ? s_diff[j][SR_W-1:0] : s_r4[j][SR_W-1:0];
      sres_nxt[j] = {sp_res[j][S_W-2:0], s_ge[j]};
      sx_nxt[j]   = sp_x[j] << 2;
    end
  end

  // All stages advance together.
  always_ff @(posedge clk) begin
    if (en_i) begin
      for (int i = 0; i <= DIV_STEPS; i++) begin
        drem_r[i] <= drem_nxt[i];
        dden_r[i] <= dden_nxt[i];
        dq_r[i]   <= dq_nxt[i];
      end
      for (int j = 0; j < SQ_STEPS; j++) begin
        srem_r[j] <= srem_nxt[j];
        sres_r[j] <= sres_nxt[j];
        sx_r[j]   <= sx_nxt[j];
      end
    end
  end

  // Largest k with (2k-1)^2 <= quotient.
  assign s_inc = {1'b0, sres_r[SQ_STEPS-1]} + (S_W+1)'(1);
  assign k_o   = s_inc[K_W:1];

endmodule

// File: hw/rtl/vector_angle_axis_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_angle_axis_top: cosine, sine and unit axis between two 3-vectors
//
//   port group | dir | contents
//   in_*       | in  | word of a_x..a_z, b_x..b_z, with in_valid / in_stall
//   out_*      | out | word of cos, sin, axis x/y/z, degenerate
//
// One word per cycle enters while the pipeline is not stalled; most of its depth is
// in the five root lanes (divider then square root, one bit a stage).
// The whole pipeline advances when the output register is empty or taken.
// Reset clears the valid bits and sideband records only; there is no clearing pass.
// ----------------------------------------------------------------------------
module vector_angle_axis_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [vaa_pkg::COORD_BITS-1:0] in_a_x,
  input  logic signed [vaa_pkg::COORD_BITS-1:0] in_a_y,
  input  logic signed [vaa_pkg::COORD_BITS-1:0] in_a_z,
  input  logic signed [vaa_pkg::COORD_BITS-1:0] in_b_x,
  input  logic signed [vaa_pkg::COORD_BITS-1:0] in_b_y,
  input  logic signed [vaa_pkg::COORD_BITS-1:0] in_b_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [vaa_pkg::W_COS-1:0]    out_cos_angle,
  output logic        [vaa_pkg::W_SIN-1:0]    out_sin_angle,
  output logic signed [vaa_pkg::W_AXIS-1:0]   out_axis_x,
  output logic signed [vaa_pkg::W_AXIS-1:0]   out_axis_y,
  output logic signed [vaa_pkg::W_AXIS-1:0]   out_axis_z,
  output logic                                out_degenerate
);

  localparam int COORD_BITS  = vaa_pkg::COORD_BITS;
  localparam int VEC_LEN     = vaa_pkg::VEC_LEN;
  localparam int PROD_W      = vaa_pkg::PROD_W;
  localparam int DOT_W       = vaa_pkg::DOT_W;
  localparam int CRS_W       = vaa_pkg::CRS_W;
  localparam int MAG_W       = vaa_pkg::MAG_W;
  localparam int SQ_W        = vaa_pkg::SQ_W;
  localparam int K_W         = vaa_pkg::K_W;
  localparam int LANE_STAGES = vaa_pkg::LANE_STAGES;
  localparam int W_COS       = vaa_pkg::W_COS;
  localparam int W_AXIS      = vaa_pkg::W_AXIS;

  logic en;

  logic signed [COORD_BITS-1:0] av [VEC_LEN];
  logic signed [COORD_BITS-1:0] bv [VEC_LEN];

  // Stage 1: coordinate products.
  logic                     s1_valid_r;
  logic signed [PROD_W-1:0] dp_r [VEC_LEN];
  logic signed [PROD_W-1:0] sa_r [VEC_LEN];
  logic signed [PROD_W-1:0] sb_r [VEC_LEN];
  logic signed [PROD_W-1:0] xp_r [VEC_LEN];
  logic signed [PROD_W-1:0] xn_r [VEC_LEN];

  // Stage 2: dot product, squared lengths, cross product.
  logic                     s2_valid_r;
  logic signed [DOT_W-1:0]  dot_r;
  logic [MAG_W-1:0]         aa_r;
  logic [MAG_W-1:0]         bb_r;
  logic signed [CRS_W-1:0]  c_r [VEC_LEN];

  // Stage 3: squares of magnitudes.
  vaa_pkg::side_t           side3_r;
  logic [SQ_W-1:0]          dot2_r;
  logic [SQ_W-1:0]          aabb_r;
  logic [SQ_W-1:0]          ci2_r [VEC_LEN];
  logic signed [DOT_W-1:0]  dot_neg;
  logic [MAG_W-1:0]         dot_mag;
  logic signed [CRS_W-1:0]  c_neg [VEC_LEN];
  logic [MAG_W-1:0]         c_mag [VEC_LEN];

  // Stage 4: squared cross length.
  vaa_pkg::side_t           side4_r;
  logic [SQ_W-1:0]          dot2_4_r;
  logic [SQ_W-1:0]          aabb_4_r;
  logic [SQ_W-1:0]          ci2_4_r [VEC_LEN];
  logic [SQ_W-1:0]          cc_r;
  logic [SQ_W+1:0]          cc_sum;

  // Sideband beside the lanes, lane results.
  vaa_pkg::side_t           side_r [LANE_STAGES];
  logic [K_W-1:0]           k_cos;
  logic [K_W-1:0]           k_sin;
  logic [K_W-1:0]           k_axis [VEC_LEN];
  vaa_pkg::side_t           side_end;

  // Output register.
  logic                     out_valid_r;
  logic signed [W_COS-1:0]  cos_r;
  logic [vaa_pkg::W_SIN-1:0] sin_r;
  logic signed [W_AXIS-1:0] axis_r [VEC_LEN];
  logic                     deg_r;
  logic signed [W_COS-1:0]  cos_nxt;
  logic [vaa_pkg::W_SIN-1:0] sin_nxt;
  logic signed [W_AXIS-1:0] axis_nxt [VEC_LEN];

  // The pipeline moves whenever the output word is absent or being taken.
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  assign av[0] = in_a_x;
  assign av[1] = in_a_y;
  assign av[2] = in_a_z;
  assign bv[0] = in_b_x;
  assign bv[1] = in_b_y;
  assign bv[2] = in_b_z;

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  // Stage 1 products; cross terms pair neighbors cyclically.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < VEC_LEN; i++) begin
        dp_r[i] <= av[i] * bv[i];
        sa_r[i] <= av[i] * av[i];
        sb_r[i] <= bv[i] * bv[i];
        xp_r[i] <= av[(i + 1) % VEC_LEN] * bv[(i + 2) % VEC_LEN];
        xn_r[i] <= av[(i + 2) % VEC_LEN] * bv[(i + 1) % VEC_LEN];
      end
    end
  end

  // Stage 2 sums.
  always_ff @(posedge clk) begin
    if (en) begin
      dot_r <= DOT_W'(dp_r[0]) + DOT_W'(dp_r[1]) + DOT_W'(dp_r[2]);
      aa_r  <= MAG_W'($unsigned(sa_r[0])) + MAG_W'($unsigned(sa_r[1]))
             + MAG_W'($unsigned(sa_r[2]));
      bb_r  <= MAG_W'($unsigned(sb_r[0])) + MAG_W'($unsigned(sb_r[1]))
             + MAG_W'($unsigned(sb_r[2]));
      for (int i = 0; i < VEC_LEN; i++) begin
        c_r[i] <= CRS_W'(xp_r[i]) - CRS_W'(xn_r[i]);
      end
    end
  end

  // Magnitudes ahead of the squaring multipliers.
  always_comb begin
    dot_neg = -dot_r;
    dot_mag = dot_r[DOT_W-1] ? dot_neg[MAG_W-1:0] : dot_r[MAG_W-1:0];
    for (int i = 0; i < VEC_LEN; i++) begin
      c_neg[i] = -c_r[i];
      c_mag[i] = c_r[i][CRS_W-1] ? c_neg[i][MAG_W-1:0] : c_r[i][MAG_W-1:0];
    end
  end

  // Stage 3 squares and the zero-vector test.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side3_r <= '0;
    end else if (en) begin
      side3_r.valid   <= s2_valid_r;
      side3_r.deg     <= (aa_r == '0) || (bb_r == '0);
      side3_r.neg_dot <= dot_r[DOT_W-1];
      for (int i = 0; i < VEC_LEN; i++) begin
        side3_r.neg_c[i] <= c_r[i][CRS_W-1];
      end
      side3_r.cc_zero <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot2_r <= dot_mag * dot_mag;
      aabb_r <= aa_r * bb_r;
      for (int i = 0; i < VEC_LEN; i++) begin
        ci2_r[i] <= c_mag[i] * c_mag[i];
      end
    end
  end

  // Stage 4: the squared cross length never exceeds |a|^2 |b|^2.
  assign cc_sum = (SQ_W+2)'(ci2_r[0]) + (SQ_W+2)'(ci2_r[1]) + (SQ_W+2)'(ci2_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side4_r <= '0;
    end else if (en) begin
      side4_r <= {side3_r.valid, side3_r.deg, side3_r.neg_dot, side3_r.neg_c,
                  (cc_sum == '0)};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot2_4_r <= dot2_r;
      aabb_4_r <= aabb_r;
      cc_r     <= cc_sum[SQ_W-1:0];
      for (int i = 0; i < VEC_LEN; i++) begin
        ci2_4_r[i] <= ci2_r[i];
      end
    end
  end

  // Root lanes.
  vaa_root_lane u_lane_cos (
    .clk   (clk),
    .en_i  (en),
    .num_i (dot2_4_r),
    .den_i (aabb_4_r),
    .k_o   (k_cos)
  );

  vaa_root_lane u_lane_sin (
    .clk   (clk),
    .en_i  (en),
    .num_i (cc_r),
    .den_i (aabb_4_r),
    .k_o   (k_sin)
  );

  for (genvar g = 0; g < VEC_LEN; g++) begin : g_axis
    vaa_root_lane u_lane_axis (
      .clk   (clk),
      .en_i  (en),
      .num_i (ci2_4_r[g]),
      .den_i (cc_r),
      .k_o   (k_axis[g])
    );
  end

  // Sideband delay line matched to the lane depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < LANE_STAGES; j++) begin
        side_r[j] <= '0;
      end
    end else if (en) begin
      side_r[0] <= side4_r;
      for (int j = 1; j < LANE_STAGES; j++) begin
        side_r[j] <= side_r[j-1];
      end
    end
  end

  assign side_end = side_r[LANE_STAGES-1];

  // Signs and the zero-vector and parallel cases.
  always_comb begin
    if (side_end.deg) begin
      cos_nxt = '0;
      sin_nxt = '0;
    end else begin
      cos_nxt = side_end.neg_dot ? -W_COS'(k_cos) : W_COS'(k_cos);
      sin_nxt = k_sin;
    end
    for (int i = 0; i < VEC_LEN; i++) begin
      if (side_end.deg || side_end.cc_zero) begin
        axis_nxt[i] = '0;
      end else begin
        axis_nxt[i] = side_end.neg_c[i] ? -W_AXIS'(k_axis[i]) : W_AXIS'(k_axis[i]);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= side_end.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
      deg_r <= side_end.deg;
      for (int i = 0; i < VEC_LEN; i++) begin
        axis_r[i] <= axis_nxt[i];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cos_angle  = cos_r;
  assign out_sin_angle  = sin_r;
  assign out_axis_x     = axis_r[0];
  assign out_axis_y     = axis_r[1];
  assign out_axis_z     = axis_r[2];
  assign out_degenerate = deg_r;

  // A zero input vector forces every result field to zero.
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_cos_angle == '0 && out_sin_angle == '0
      && out_axis_x == '0 && out_axis_y == '0 && out_axis_z == '0)
    else $error("degenerate word carries nonzero results");

  // The sine never exceeds 1.0.
  a_sin_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sin_angle <= vaa_pkg::ONE)
    else $error("sine beyond 1.0");

  // Input is held back only while a finished word waits downstream.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting output word");

endmodule

// File: verif/tb_vector_angle_axis_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_angle_axis_top: self-checking bench for the angle/axis pipeline
// Drives vector pairs with random idle bursts on both channels. Every accepted
// word is scored against an exact integer predictor of cosine, sine and unit
// axis, with the results checked in order.
// ----------------------------------------------------------------------------
module tb_vector_angle_axis_top;

  localparam int COORD_BITS = vaa_pkg::COORD_BITS;
  localparam int FRAC_BITS  = vaa_pkg::FRAC_BITS;
  localparam int W_COS      = vaa_pkg::W_COS;
  localparam int W_SIN      = vaa_pkg::W_SIN;
  localparam int W_AXIS     = vaa_pkg::W_AXIS;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax, ay, az, bx, by, bz;
  } pair_t;

  typedef struct packed {
    logic signed [W_COS-1:0]  cos_v;
    logic        [W_SIN-1:0]  sin_v;
    logic signed [W_AXIS-1:0] x, y, z;
    logic                     deg;
  } angle_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int QUIET_TAIL     = 150;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [COORD_BITS-1:0] in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z;
  logic signed [W_COS-1:0]  out_cos_angle;
  logic        [W_SIN-1:0]  out_sin_angle;
  logic signed [W_AXIS-1:0] out_axis_x, out_axis_y, out_axis_z;
  logic                     out_degenerate;

  pair_t  pending_pairs[$];
  angle_t expected_angles[$];
  int     mismatches;
  int     sent_words;
  int     drain_point;
  int     in_gap, out_gap, idle_cycles;

  vector_angle_axis_top dut (.*);

  // Clock: 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Nearest q to 2^FRAC_BITS * sqrt(num / den), capped at one.
  function automatic int unsigned root_code(logic [63:0] num, logic [63:0] den);
    logic [127:0] lhs;
    logic [127:0] rhs;
    int unsigned  lo, hi, k;
    logic [63:0]  t;
    lhs = {64'd0, num} << (2 * FRAC_BITS + 2);
    lo = 0;
    hi = 1 << FRAC_BITS;
    while (lo < hi) begin
      k = lo + (hi - lo + 1) / 2;
      t = 2 * k - 1;
      rhs = {64'd0, t * t} * {64'd0, den};
      if (lhs >= rhs) lo = k;
      else hi = k - 1;
    end
    return lo;
  endfunction

  // Signed value over sqrt(den), rounded away from zero on ties.
  function automatic logic signed [15:0] signed_code(longint v, logic [63:0] den);
    logic [63:0] mag;
    int          q;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    q = root_code(mag * mag, den);
    return 16'((v < 0) ? -q : q);
  endfunction

  // Cosine, sine and unit axis of one vector pair.
  function automatic angle_t angle_between(pair_t p);
    angle_t      r;
    longint      ax, ay, az, bx, by, bz, dot, aa, bb, cx, cy, cz;
    logic [63:0] lens, cc;
    ax = p.ax; ay = p.ay; az = p.az;
    bx = p.bx; by = p.by; bz = p.bz;
    dot = ax * bx + ay * by + az * bz;
    aa = ax * ax + ay * ay + az * az;
    bb = bx * bx + by * by + bz * bz;
    cx = ay * bz - az * by;
    cy = az * bx - ax * bz;
    cz = ax * by - ay * bx;
    cc = 64'(cx * cx) + 64'(cy * cy) + 64'(cz * cz);
    r = '0;
    if (aa == 0 || bb == 0) begin
      r.deg = 1'b1;
      return r;
    end
    lens = 64'(aa) * 64'(bb);
    r.cos_v = signed_code(dot, lens);
    r.sin_v = W_SIN'(root_code(cc, lens));
    if (cc != 0) begin
      r.x = signed_code(cx, cc);
      r.y = signed_code(cy, cc);
      r.z = signed_code(cz, cc);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  function automatic logic signed [15:0] rand_coord();
    return 16'($urandom);
  endfunction

  // Small components, so that parallel multiples stay in range.
  function automatic pair_t parallel_pair();
    pair_t p;
    int    k;
    k = $urandom_range(0, 60) - 30;
    p.ax = 16'($urandom_range(0, 2000) - 1000);
    p.ay = 16'($urandom_range(0, 2000) - 1000);
    p.az = 16'($urandom_range(0, 2000) - 1000);
    p.bx = 16'(k * p.ax);
    p.by = 16'(k * p.ay);
    p.bz = 16'(k * p.az);
    return p;
  endfunction

  // Driver: presents pending words, with idle bursts and one drain pause.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_angles.push_back(angle_between({in_a_x, in_a_y, in_a_z,
                                                 in_b_x, in_b_y, in_b_z}));
        sent_words <= sent_words + 1;
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_pairs.size() == 0 ||
                   (sent_words + (in_valid ? 1 : 0) == drain_point &&
                    (expected_angles.size() != 0 || in_valid))) begin
        in_valid <= 1'b0;
      end else if (pending_pairs.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        in_gap <= $urandom_range(0, 10);
      end else begin
        pair_t p;
        p = pending_pairs.pop_front();
        in_valid <= 1'b1;
        {in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z} <= p;
      end
    end
  end

  // Monitor: random stall bursts on the result side, in-order scoring.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_angles.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          angle_t e;
          e = expected_angles.pop_front();
          if (out_cos_angle !== e.cos_v) report_mismatch("cos", out_cos_angle, e.cos_v);
          if (out_sin_angle !== e.sin_v) report_mismatch("sin", out_sin_angle, e.sin_v);
          if (out_axis_x !== e.x) report_mismatch("axis_x", out_axis_x, e.x);
          if (out_axis_y !== e.y) report_mismatch("axis_y", out_axis_y, e.y);
          if (out_axis_z !== e.z) report_mismatch("axis_z", out_axis_z, e.z);
          if (out_degenerate !== e.deg)
            report_mismatch("degenerate", out_degenerate, e.deg);
        end
      end
      if (out_gap > 0) begin
        out_stall <= 1'b1;
        out_gap <= out_gap - 1;
      end else if (pending_pairs.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        out_gap <= $urandom_range(0, 10);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run when no word moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_vector_angle_axis_top failed");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    pair_t p;
    int    sel;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    {in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z} = '0;
    mismatches = 0;
    sent_words = 0;
    in_gap = 0;
    out_gap = 0;
    idle_cycles = 0;

    // Directed: zero vectors, parallel, antiparallel, orthogonal, extremes.
    pending_pairs.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd2, 16'sd3});
    pending_pairs.push_back({16'sd5, -16'sd7, 16'sd9, 16'sd0, 16'sd0, 16'sd0});
    pending_pairs.push_back('0);
    pending_pairs.push_back({16'sd1, 16'sd2, 16'sd3, 16'sd2, 16'sd4, 16'sd6});
    pending_pairs.push_back({16'sd1, 16'sd2, 16'sd3, -16'sd3, -16'sd6, -16'sd9});
    pending_pairs.push_back({16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0});
    pending_pairs.push_back({16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd0, 16'sd0});
    pending_pairs.push_back({16'sd0, 16'sd3, 16'sd0, 16'sd0, 16'sd0, -16'sd5});
    pending_pairs.push_back({6{16'h8000}});
    pending_pairs.push_back({6{16'h7fff}});
    pending_pairs.push_back({{3{16'h8000}}, {3{16'h7fff}}});
    pending_pairs.push_back({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
    pending_pairs.push_back({16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0000});
    pending_pairs.push_back({16'h8000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000});
    pending_pairs.push_back({16'sd1, 16'sd1, 16'sd0, 16'sd1, 16'sd0, 16'sd0});
    pending_pairs.push_back({16'sd1, 16'sd1, 16'sd1, 16'sd1, -16'sd1, 16'sd0});
    pending_pairs.push_back({16'sd3, 16'sd4, 16'sd0, 16'sd4, 16'sd3, 16'sd0});
    pending_pairs.push_back({16'hffff, 16'hffff, 16'hffff, 16'h0001, 16'h0001, 16'h0002});
    pending_pairs.push_back({16'h8000, 16'h8000, 16'h0000, 16'h8000, 16'h0000, 16'h8000});
    pending_pairs.push_back({16'h7fff, 16'h7ffe, 16'h7fff, 16'h7ffe, 16'h7fff, 16'h7ffe});
    drain_point = pending_pairs.size();

    // Random: full range, small values, parallel multiples, some zero vectors.
    repeat (1400) begin
      sel = $urandom_range(0, 19);
      if (sel < 10) begin
        p = {rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord()};
      end else if (sel < 14) begin
        p.ax = 16'($urandom_range(0, 16) - 8);
        p.ay = 16'($urandom_range(0, 16) - 8);
        p.az = 16'($urandom_range(0, 16) - 8);
        p.bx = 16'($urandom_range(0, 16) - 8);
        p.by = 16'($urandom_range(0, 16) - 8);
        p.bz = 16'($urandom_range(0, 16) - 8);
      end else if (sel < 18) begin
        p = parallel_pair();
      end else begin
        p = {rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord()};
        if (sel == 18) {p.ax, p.ay, p.az} = '0;
        else {p.bx, p.by, p.bz} = '0;
      end
      pending_pairs.push_back(p);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_pairs.size() != 0 || in_valid) @(posedge clk);
    while (expected_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_angles.size() == 0) begin
      $display("tb_vector_angle_axis_top passed");
    end else begin
      $display("tb_vector_angle_axis_top failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/vaa_pkg.sv
hw/rtl/vaa_root_lane.sv
hw/rtl/vector_angle_axis_top.sv
verif/tb_vector_angle_axis_top.sv
